FILE: design/dhot_pkg.sv
`timescale 1ns / 1ps

package dhot_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int HASH_W = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W = 11;
  localparam int MARK_W = 2;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  // Hash bits reduced per cycle by the remainder unit.
  localparam int REM_BITS = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd4;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [MARK_W-1:0] MARK_VACATED = 2'd2;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

endpackage

FILE: design/dhot_ram.sv
`timescale 1ns / 1ps

module dhot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/dhot_rem.sv
`timescale 1ns / 1ps

module dhot_rem import dhot_pkg::*; #(
  parameter int EW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [HASH_W-1:0] dividend_one,
  input  logic [HASH_W-1:0] dividend_two,
  input  logic [EW-1:0]     divisor,
  output logic              done,
  output logic [EW-1:0]     rem_one,
  output logic [EW-1:0]     rem_two
);

  localparam int CYCLES = HASH_W / REM_BITS;
  localparam int CW = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic              run;
  logic [CW-1:0]     cnt;
  logic [HASH_W-1:0] d_one;
  logic [HASH_W-1:0] d_two;
  logic [EW-1:0]     div_r;
  logic [EW-1:0]     rem_one_next;
  logic [EW-1:0]     rem_two_next;

  function automatic logic [EW-1:0] rem_step(input logic [EW-1:0] r, input logic b,
                                             input logic [EW-1:0] p);
    logic [EW:0] t;
    t = {r, b};
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    return t[EW-1:0];
  endfunction

  always_comb begin
    rem_one_next = rem_one;
    rem_two_next = rem_two;
    for (int j = 0; j < REM_BITS; j++) begin
      rem_one_next = rem_step(rem_one_next, d_one[HASH_W-1-j], div_r);
      rem_two_next = rem_step(rem_two_next, d_two[HASH_W-1-j], div_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= '0;
        d_one <= dividend_one;
        d_two <= dividend_two;
        div_r <= divisor;
        rem_one <= '0;
        rem_two <= '0;
      end else if (run) begin
        rem_one <= rem_one_next;
        rem_two <= rem_two_next;
        d_one <= d_one << REM_BITS;
        d_two <= d_two << REM_BITS;
        if (cnt == CW'(CYCLES - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/double_hash_open_table_unit.sv
`timescale 1ns / 1ps

// An insert on a full table or an unused func code answers in the cycle after the transfer.
// Other operations first reduce the hashes modulo the slot count, then probe the slots
// one after another through the table memory.
// A new item is taken once done is shown; the receiver cannot stall results.
// After reset, busy stays high while every slot is marked empty.
module double_hash_open_table_unit import dhot_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func,
  input  logic [KEY_W-1:0]    key,
  input  logic [PAY_W-1:0]    payload_in,
  input  logic [HASH_W-1:0]   hash_one,
  input  logic [HASH_W-1:0]   hash_two,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [PAY_W-1:0]    payload_out,
  output logic [CFG_W-1:0]    entry_count,
  input  logic                cfg_write,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int PMAX = (TABLE_DEPTH < CFG_MAX) ? TABLE_DEPTH : CFG_MAX;
  localparam int EW = $clog2(PMAX + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_HASH   = 4'b0100,
    S_SEARCH = 4'b1000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  positions_in_use;
  logic [CFG_W-1:0]  occ_count;
  logic [AW-1:0]     clr_addr;
  logic [EW-1:0]     p_eff;
  logic [EW-1:0]     p_cur;
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [PAY_W-1:0]  pay_r;

  logic [EW-1:0] pos;
  logic [EW-1:0] pos_next;
  logic [EW:0]   pos_sum;
  logic [EW-1:0] step;
  logic [EW-1:0] issued;
  logic          issue;
  logic          chk_valid;
  logic          chk_last;
  logic [EW-1:0] chk_pos;
  logic          tomb_valid;
  logic [EW-1:0] tomb_pos;

  logic          accept;
  logic          immediate;
  logic          rem_done;
  logic [EW-1:0] rem_one;
  logic [EW-1:0] rem_two;

  entry_t        rd_entry;
  logic          hit;
  logic          is_empty;
  logic          is_free;
  logic [EW-1:0] free_pos;
  logic          fin;
  logic [STATUS_W-1:0] fin_status;
  logic [PAY_W-1:0]    fin_pay;
  logic          cnt_inc;
  logic          cnt_dec;
  logic          upd_en;
  logic [EW-1:0] upd_pos;
  entry_t        upd_data;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;

  assign busy = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign entry_count = occ_count;

  always_comb begin
    if (positions_in_use == '0) begin
      p_eff = EW'(1);
    end else if (positions_in_use > CFG_W'(PMAX)) begin
      p_eff = EW'(PMAX);
    end else begin
      p_eff = EW'(positions_in_use);
    end
  end

  assign immediate = (func == FUNC_NONE) ||
                     ((func == FUNC_INSERT) && (occ_count >= CFG_W'(p_eff)));

  dhot_rem #(
    .EW(EW)
  ) u_rem (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && !immediate),
    .dividend_one (hash_one),
    .dividend_two (hash_two),
    .divisor      (p_eff),
    .done         (rem_done),
    .rem_one      (rem_one),
    .rem_two      (rem_two)
  );

  assign issue = (issued != p_cur);
  assign pos_sum = {1'b0, pos} + {1'b0, step};
  assign pos_next = (pos_sum >= {1'b0, p_cur}) ? EW'(pos_sum - {1'b0, p_cur}) : pos_sum[EW-1:0];

  always_comb begin
    hit = (rd_entry.mark == MARK_OCCUPIED) && (rd_entry.key == key_r);
    is_empty = (rd_entry.mark == MARK_EMPTY);
    is_free = (rd_entry.mark != MARK_OCCUPIED);
    free_pos = tomb_valid ? tomb_pos : chk_pos;
    fin = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_pay = '0;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    upd_en = 1'b0;
    upd_pos = chk_pos;
    upd_data.mark = MARK_OCCUPIED;
    upd_data.key = key_r;
    upd_data.payload = pay_r;
    if ((state == S_SEARCH) && chk_valid) begin
      if (hit) begin
        fin = 1'b1;
        if (func_r == FUNC_INSERT) begin
          fin_status = ST_PRESENT;
        end else begin
          fin_status = ST_OK;
          fin_pay = rd_entry.payload;
          if (func_r == FUNC_REMOVE) begin
            upd_en = 1'b1;
            upd_data.mark = MARK_VACATED;
            upd_data.key = rd_entry.key;
            upd_data.payload = rd_entry.payload;
            cnt_dec = (occ_count != '0);
          end
        end
      end else if (is_empty || chk_last) begin
        fin = 1'b1;
        if (func_r == FUNC_INSERT) begin
          if (tomb_valid || is_free) begin
            fin_status = ST_OK;
            upd_en = 1'b1;
            upd_pos = free_pos;
            cnt_inc = 1'b1;
          end else begin
            fin_status = ST_NO_SLOT;
          end
        end
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = upd_en;
      ram_waddr = AW'(upd_pos);
      ram_wdata = upd_data;
    end
  end

  dhot_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(pos)),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      occ_count <= '0;
      positions_in_use <= CFG_RESET;
      done <= 1'b0;
      chk_valid <= 1'b0;
      chk_last <= 1'b0;
      tomb_valid <= 1'b0;
      issued <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        positions_in_use <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func_r <= func;
            key_r <= key;
            pay_r <= payload_in;
            p_cur <= p_eff;
            if (immediate) begin
              done <= 1'b1;
              status <= (func == FUNC_INSERT) ? ST_FULL : ST_NOT_FOUND;
              payload_out <= '0;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (rem_done) begin
            pos <= rem_one;
            step <= rem_two;
            issued <= '0;
            chk_valid <= 1'b0;
            chk_last <= 1'b0;
            tomb_valid <= 1'b0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          chk_valid <= issue;
          chk_last <= issue && (issued == p_cur - 1'b1);
          chk_pos <= pos;
          if (issue) begin
            pos <= pos_next;
            issued <= issued + 1'b1;
          end
          if (chk_valid && !fin && is_free && !tomb_valid) begin
            tomb_valid <= 1'b1;
            tomb_pos <= chk_pos;
          end
          if (fin) begin
            state <= S_IDLE;
            done <= 1'b1;
            status <= fin_status;
            payload_out <= fin_pay;
            if (cnt_inc) begin
              occ_count <= occ_count + 1'b1;
            end else if (cnt_dec) begin
              occ_count <= occ_count - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/dhot_check.sv
`timescale 1ns / 1ps

module dhot_check import dhot_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [FUNC_W-1:0]   func,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic [PAY_W-1:0]    payload_out,
  input logic [CFG_W-1:0]    entry_count
);

  // An unused function code is answered in the next cycle as not found.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (func == FUNC_NONE) |=> done && (status == ST_NOT_FOUND))
  else $error("unused function code not answered at once");

  // Only a successful lookup or remove returns a payload.
  assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (payload_out == '0))
  else $error("payload returned with a failing status");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK) || (status == ST_PRESENT) || (status == ST_FULL) ||
             (status == ST_NOT_FOUND) || (status == ST_NO_SLOT))
  else $error("status code out of range");

  // The entry count moves only together with a result transfer, and by one at most.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(entry_count) |-> done && (status == ST_OK))
  else $error("entry count changed without a completed operation");

endmodule

bind double_hash_open_table_unit dhot_check u_dhot_check (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import dhot_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEFAULT;
  localparam int KEY_POOL = 40;
  localparam longint CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAY_W-1:0]    payload;
    logic [CFG_W-1:0]    count;
  } lookup_result_t;

  typedef struct {
    bit                  is_cfg;
    logic [CFG_W-1:0]    cfg_value;
    logic [FUNC_W-1:0]   op;
    logic [KEY_W-1:0]    k;
    logic [PAY_W-1:0]    pay;
    logic [HASH_W-1:0]   h1;
    logic [HASH_W-1:0]   h2;
    bit                  typed;
    lookup_result_t      want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   func;
  logic [KEY_W-1:0]    key;
  logic [PAY_W-1:0]    payload_in;
  logic [HASH_W-1:0]   hash_one;
  logic [HASH_W-1:0]   hash_two;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [PAY_W-1:0]    payload_out;
  logic [CFG_W-1:0]    entry_count;
  logic                cfg_write;
  logic [CFG_W-1:0]    cfg_data;

  logic [MARK_W-1:0]   slot_state [TABLE_DEPTH];
  logic [KEY_W-1:0]    slot_keys [TABLE_DEPTH];
  logic [PAY_W-1:0]    slot_data [TABLE_DEPTH];
  int unsigned         stored_count;
  logic [CFG_W-1:0]    slots_in_use;

  lookup_result_t      pending_results [$];
  lookup_result_t      oldest;
  stim_row_t           stim_rows [$];
  logic [KEY_W-1:0]    key_pool [KEY_POOL];
  int unsigned         phase_cfg [9] = '{1, 0, 3, 7, 12, 16, 64, 2047, 5};
  int unsigned         idle_pct [3] = '{0, 85, 35};
  int                  errors;
  longint              cycles;

  double_hash_open_table_unit i_dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending transfer", 32'(status), 32'h0);
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status)
          report_mismatch("status", 32'(status), 32'(oldest.status));
        if (payload_out !== oldest.payload)
          report_mismatch("payload_out", payload_out, oldest.payload);
        if (entry_count !== oldest.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(oldest.count));
      end
    end
  end

  function automatic int unsigned active_slots();
    int unsigned p;
    p = slots_in_use;
    if (p == 0) p = 1;
    if (p > TABLE_DEPTH) p = TABLE_DEPTH;
    return p;
  endfunction

  function automatic int unsigned slot_at(logic [HASH_W-1:0] h1, logic [HASH_W-1:0] h2,
                                          int unsigned i, int unsigned p);
    longint unsigned s;
    s = h1;
    s = s + longint'(i) * longint'(h2);
    return int'(s % p);
  endfunction

  function automatic bit locate(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h1,
                                logic [HASH_W-1:0] h2, output int unsigned where);
    int unsigned p;
    int unsigned pos;
    p = active_slots();
    where = 0;
    for (int unsigned i = 0; i < p; i++) begin
      pos = slot_at(h1, h2, i, p);
      if (slot_state[pos] == MARK_EMPTY) return 0;
      if (slot_state[pos] == MARK_OCCUPIED && slot_keys[pos] == k) begin
        where = pos;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic lookup_result_t table_apply(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                                                 logic [PAY_W-1:0] pay,
                                                 logic [HASH_W-1:0] h1,
                                                 logic [HASH_W-1:0] h2);
    lookup_result_t r;
    int unsigned p;
    int unsigned pos;
    p = active_slots();
    r.status = ST_NOT_FOUND;
    r.payload = '0;
    case (op)
      FUNC_INSERT: begin
        if (stored_count >= p) begin
          r.status = ST_FULL;
        end else if (locate(k, h1, h2, pos)) begin
          r.status = ST_PRESENT;
        end else begin
          r.status = ST_NO_SLOT;
          for (int unsigned i = 0; i < p; i++) begin
            pos = slot_at(h1, h2, i, p);
            if (slot_state[pos] != MARK_OCCUPIED) begin
              slot_state[pos] = MARK_OCCUPIED;
              slot_keys[pos] = k;
              slot_data[pos] = pay;
              stored_count++;
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      FUNC_REMOVE: begin
        if (locate(k, h1, h2, pos)) begin
          r.payload = slot_data[pos];
          slot_state[pos] = MARK_VACATED;
          if (stored_count > 0) stored_count--;
          r.status = ST_OK;
        end
      end
      FUNC_LOOKUP: begin
        if (locate(k, h1, h2, pos)) begin
          r.payload = slot_data[pos];
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.count = CFG_W'(stored_count);
    return r;
  endfunction

  function automatic logic [2*HASH_W-1:0] key_hashes(logic [KEY_W-1:0] k);
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
    h1 = k[15:0] ^ {k[23:16], k[31:24]};
    h2 = k[31:16] ^ {k[7:0], k[15:8]} ^ 16'h5bd1;
    return {h1, h2};
  endfunction

  function automatic stim_row_t op_row(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                                       logic [PAY_W-1:0] pay, logic [HASH_W-1:0] h1,
                                       logic [HASH_W-1:0] h2, bit typed,
                                       logic [STATUS_W-1:0] st, logic [PAY_W-1:0] po,
                                       logic [CFG_W-1:0] cnt);
    stim_row_t row;
    row.is_cfg = 0;
    row.cfg_value = '0;
    row.op = op;
    row.k = k;
    row.pay = pay;
    row.h1 = h1;
    row.h2 = h2;
    row.typed = typed;
    row.want = '{st, po, cnt};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_W-1:0] v);
    stim_row_t row;
    row = op_row(FUNC_NONE, '0, '0, '0, '0, 0, ST_OK, '0, '0);
    row.is_cfg = 1;
    row.cfg_value = v;
    return row;
  endfunction

  task automatic hold_off();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_op(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                        input logic [PAY_W-1:0] pay, input logic [HASH_W-1:0] h1,
                        input logic [HASH_W-1:0] h2, input bit typed,
                        input lookup_result_t want);
    lookup_result_t predicted;
    start <= 1'b1;
    func <= op;
    key <= k;
    payload_in <= pay;
    hash_one <= h1;
    hash_two <= h2;
    do @(posedge clk); while (busy);
    predicted = table_apply(op, k, pay, h1, h2);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] v);
    hold_off();
    while (pending_results.size() != 0 || busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    slots_in_use = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_op();
    logic [FUNC_W-1:0]   op;
    logic [KEY_W-1:0]    k;
    logic [2*HASH_W-1:0] h;
    int unsigned         sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) op = FUNC_INSERT;
    else if (sel < 70) op = FUNC_LOOKUP;
    else if (sel < 95) op = FUNC_REMOVE;
    else op = FUNC_NONE;
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom;
      h = $urandom;
    end else begin
      k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      h = key_hashes(k);
    end
    run_op(op, k, $urandom, h[31:16], h[15:0], 0, '0);
  endtask

  initial begin
    logic [2*HASH_W-1:0] h;
    int unsigned pct;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_NONE;
    key = '0;
    payload_in = '0;
    hash_one = '0;
    hash_two = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    stored_count = 0;
    slots_in_use = CFG_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_state[i] = MARK_EMPTY;
      slot_keys[i] = '0;
      slot_data[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 1,
                               ST_NOT_FOUND, 32'h0, 11'd0));
    stim_rows.push_back(op_row(FUNC_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
                               1, ST_NOT_FOUND, 32'h0, 11'd0));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'h0, 32'hffff_ffff, 16'h0, 16'h0, 1,
                               ST_OK, 32'h0, 11'd1));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'h0, 32'h1111_1111, 16'h0, 16'h0, 1,
                               ST_PRESENT, 32'h0, 11'd1));
    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 1,
                               ST_OK, 32'hffff_ffff, 11'd1));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'hffff_ffff, 32'h0, 16'hffff, 16'hffff, 1,
                               ST_OK, 32'h0, 11'd2));
    stim_rows.push_back(op_row(FUNC_NONE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
                               1, ST_NOT_FOUND, 32'h0, 11'd2));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'h1, 32'h2222_2222, 16'h0, 16'h0, 1,
                               ST_NO_SLOT, 32'h0, 11'd2));
    stim_rows.push_back(op_row(FUNC_REMOVE, 32'h0, 32'h0, 16'h0, 16'h0, 1,
                               ST_OK, 32'hffff_ffff, 11'd1));
    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 1,
                               ST_NOT_FOUND, 32'h0, 11'd1));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'h1, 32'ha5a5_5a5a, 16'h0, 16'h0, 1,
                               ST_OK, 32'h0, 11'd2));
    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h1, 32'h0, 16'h0, 16'h0, 1,
                               ST_OK, 32'ha5a5_5a5a, 11'd2));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'h2, 32'h1234_5678, 16'h0400, 16'h0001, 0,
                               ST_OK, 32'h0, 11'd0));
    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h2, 32'h0, 16'h0400, 16'h0001, 0,
                               ST_OK, 32'h0, 11'd0));
    stim_rows.push_back(op_row(FUNC_REMOVE, 32'hffff_ffff, 32'h0, 16'hffff, 16'hffff, 1,
                               ST_OK, 32'h0, 11'd2));
    stim_rows.push_back(cfg_row(11'd0));
    stim_rows.push_back(op_row(FUNC_INSERT, 32'h3, 32'h3333_3333, 16'h0005, 16'h0007, 1,
                               ST_FULL, 32'h0, 11'd2));
    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h1, 32'h0, 16'h0, 16'h0, 1,
                               ST_OK, 32'ha5a5_5a5a, 11'd2));
    stim_rows.push_back(op_row(FUNC_REMOVE, 32'h2, 32'h0, 16'h0400, 16'h0001, 1,
                               ST_NOT_FOUND, 32'h0, 11'd2));
    stim_rows.push_back(cfg_row(11'd2047));
    stim_rows.push_back(op_row(FUNC_LOOKUP, 32'h2, 32'h0, 16'h0400, 16'h0001, 1,
                               ST_OK, 32'h1234_5678, 11'd2));
    stim_rows.push_back(op_row(FUNC_REMOVE, 32'h2, 32'h0, 16'h0400, 16'h0001, 1,
                               ST_OK, 32'h1234_5678, 11'd1));
    stim_rows.push_back(op_row(FUNC_REMOVE, 32'h1, 32'h0, 16'h0, 16'h0, 1,
                               ST_OK, 32'ha5a5_5a5a, 11'd0));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        write_cfg(stim_rows[i].cfg_value);
      end else begin
        run_op(stim_rows[i].op, stim_rows[i].k, stim_rows[i].pay, stim_rows[i].h1,
               stim_rows[i].h2, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      write_cfg(CFG_W'(phase_cfg[ph]));
      pct = idle_pct[ph % 3];
      for (int n = 0; n < 80; n++) begin
        random_op();
        if (n == 40) begin
          hold_off();
          while (pending_results.size() != 0) @(posedge clk);
        end else if ((n / 20) % 2 == 1 && $urandom_range(0, 99) < pct) begin
          hold_off();
          while ($urandom_range(0, 99) < pct) @(posedge clk);
        end
      end
      // Leave the table populated before the final shrink so stranded entries stay counted.
      if (ph != 7) begin
        for (int i = 0; i < KEY_POOL; i++) begin
          h = key_hashes(key_pool[i]);
          run_op(FUNC_REMOVE, key_pool[i], $urandom, h[31:16], h[15:0], 0, '0);
        end
      end
    end

    hold_off();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dhot_pkg.sv
design/dhot_ram.sv
design/dhot_rem.sv
design/double_hash_open_table_unit.sv
design/dhot_check.sv
verif/tb.sv
